>>> hdl/ufb_pkg.sv
// Shared types, constants and header byte lookup for the UDP/IPv4 frame builder.
// Used by ufb_front, ufb_fifo, ufb_back and udp_ipv4_frame_builder.
`timescale 1ns / 1ps

package ufb_pkg;

	localparam int MAC_W      = 48;
	localparam int IP_W       = 32;
	localparam int PORT_W     = 16;
	localparam int PLEN_W     = 10;
	localparam int BYTE_W     = 8;
	localparam int LEN_W      = PLEN_W + 1;
	localparam int SUM_PART_W = 18;
	localparam int SUM_W      = 19;
	localparam int HDR_BYTES  = 42;
	localparam int HDR_IDX_W  = 6;

	localparam int S_TDATA_W  = 120;
	localparam int M_TDATA_W  = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;

	localparam int MAX_FRAME_BYTES_DEF = 1024;
	localparam int FIFO_DEPTH_DEF      = 4;

	// input item kinds
	localparam logic OP_START   = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MAC  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_IP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_PORT = 2'd2;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  IP_VER_IHL     = 8'h45;
	localparam logic [7:0]  IP_FLAGS_DF    = 8'h40;
	localparam logic [7:0]  IP_TTL         = 8'h40;
	localparam logic [7:0]  IP_PROTO_UDP   = 8'h11;
	localparam logic [15:0] IP_LEN_BASE    = 16'd28;
	localparam logic [15:0] UDP_LEN_BASE   = 16'd8;

	localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HDR_BYTES - 1);

	// checksum contribution of the fixed IP header words plus the length base
	localparam logic [SUM_PART_W-1:0] CSUM_FIXED =
		SUM_PART_W'({IP_VER_IHL, 8'h00}) + SUM_PART_W'({IP_FLAGS_DF, 8'h00}) +
		SUM_PART_W'({IP_TTL, IP_PROTO_UDP}) + SUM_PART_W'(IP_LEN_BASE);

	typedef enum logic [1:0] {
		CMD_HDR,
		CMD_DATA,
		CMD_ERR
	} ufb_cmd_kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_HDR
	} ufb_back_state_t;

	typedef struct packed {
		ufb_cmd_kind_t           kind;
		logic [MAC_W-1:0]        dst_mac;
		logic [IP_W-1:0]         dest_ip;
		logic [PORT_W-1:0]       dst_port;
		logic [PLEN_W-1:0]       plen;
		logic [BYTE_W-1:0]       data;
		logic                    last;
		logic [SUM_PART_W-1:0]   csum_part;
	} ufb_cmd_t;

	typedef struct packed {
		logic [MAC_W-1:0]  source_mac;
		logic [IP_W-1:0]   source_ip;
		logic [PORT_W-1:0] source_port;
	} ufb_cfg_t;

	function automatic logic [BYTE_W-1:0] hdr_byte(
		input logic [HDR_IDX_W-1:0] idx,
		input ufb_cfg_t             cfg,
		input logic [MAC_W-1:0]     dmac,
		input logic [IP_W-1:0]      dip,
		input logic [PORT_W-1:0]    dport,
		input logic [PLEN_W-1:0]    plen,
		input logic [15:0]          csum
	);
		logic [15:0] tot_len;
		logic [15:0] udp_len;
		logic [BYTE_W-1:0] b;
		tot_len = IP_LEN_BASE + 16'(plen);
		udp_len = UDP_LEN_BASE + 16'(plen);
		unique case (idx)
			6'd0:  b = dmac[47:40];
			6'd1:  b = dmac[39:32];
			6'd2:  b = dmac[31:24];
			6'd3:  b = dmac[23:16];
			6'd4:  b = dmac[15:8];
			6'd5:  b = dmac[7:0];
			6'd6:  b = cfg.source_mac[47:40];
			6'd7:  b = cfg.source_mac[39:32];
			6'd8:  b = cfg.source_mac[31:24];
			6'd9:  b = cfg.source_mac[23:16];
			6'd10: b = cfg.source_mac[15:8];
			6'd11: b = cfg.source_mac[7:0];
			6'd12: b = ETHERTYPE_IPV4[15:8];
			6'd13: b = ETHERTYPE_IPV4[7:0];
			6'd14: b = IP_VER_IHL;
			6'd16: b = tot_len[15:8];
			6'd17: b = tot_len[7:0];
			6'd20: b = IP_FLAGS_DF;
			6'd22: b = IP_TTL;
			6'd23: b = IP_PROTO_UDP;
			6'd24: b = csum[15:8];
			6'd25: b = csum[7:0];
			6'd26: b = cfg.source_ip[31:24];
			6'd27: b = cfg.source_ip[23:16];
			6'd28: b = cfg.source_ip[15:8];
			6'd29: b = cfg.source_ip[7:0];
			6'd30: b = dip[31:24];
			6'd31: b = dip[23:16];
			6'd32: b = dip[15:8];
			6'd33: b = dip[7:0];
			6'd34: b = cfg.source_port[15:8];
			6'd35: b = cfg.source_port[7:0];
			6'd36: b = dport[15:8];
			6'd37: b = dport[7:0];
			6'd38: b = udp_len[15:8];
			6'd39: b = udp_len[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

>>> hdl/ufb_front.sv
// Front end: accepts input items, tracks the open packet and classifies each item.
// Depends on ufb_pkg.
`timescale 1ns / 1ps

module ufb_front #(
	parameter int MAX_FRAME_BYTES = ufb_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// dst_mac, dest_ip, dst_port, pay_len, payload_byte, zero fill
	input  logic [ufb_pkg::S_TDATA_W-1:0]  s_tdata,
	// operation
	input  logic                           s_tuser,
	output logic                           cmd_valid,
	input  logic                           cmd_ready,
	output ufb_pkg::ufb_cmd_t              cmd
);
	import ufb_pkg::*;

	logic [MAC_W-1:0]  in_mac;
	logic [IP_W-1:0]   in_ip;
	logic [PORT_W-1:0] in_port;
	logic [PLEN_W-1:0] in_plen;
	logic [BYTE_W-1:0] in_byte;

	logic              open_q;
	logic [PLEN_W-1:0] rem_q;
	logic              open_d;
	logic [PLEN_W-1:0] rem_d;
	logic [PLEN_W-1:0] rem_dec;
	logic              oversize;
	logic              accept;
	ufb_cmd_t          cmd_d;
	ufb_cmd_t          cmd_s1;
	logic              valid_s1;

	assign in_mac  = s_tdata[47:0];
	assign in_ip   = s_tdata[79:48];
	assign in_port = s_tdata[95:80];
	assign in_plen = s_tdata[105:96];
	assign in_byte = s_tdata[113:106];

	assign s_tready = !valid_s1 || cmd_ready;
	assign accept   = s_tvalid && s_tready;
	assign rem_dec  = rem_q - PLEN_W'(1);
	assign oversize = (LEN_W'(in_plen) + LEN_W'(HDR_BYTES)) > LEN_W'(MAX_FRAME_BYTES);

	always_comb begin
		cmd_d.kind      = CMD_ERR;
		cmd_d.dst_mac   = in_mac;
		cmd_d.dest_ip   = in_ip;
		cmd_d.dst_port  = in_port;
		cmd_d.plen      = in_plen;
		cmd_d.data      = in_byte;
		cmd_d.last      = 1'b0;
		cmd_d.csum_part = SUM_PART_W'(in_ip[31:16]) + SUM_PART_W'(in_ip[15:0]) +
			SUM_PART_W'(in_plen) + CSUM_FIXED;
		open_d = open_q;
		rem_d  = rem_q;
		if (s_tuser == OP_PAYLOAD) begin
			if (open_q) begin
				cmd_d.kind = CMD_DATA;
				cmd_d.last = (rem_dec == '0);
				open_d     = (rem_dec != '0);
				rem_d      = rem_dec;
			end
		end else begin
			// a new start drops any open packet
			open_d = 1'b0;
			rem_d  = '0;
			if (!oversize) begin
				cmd_d.kind = CMD_HDR;
				cmd_d.last = (in_plen == '0);
				if (in_plen != '0) begin
					open_d = 1'b1;
					rem_d  = in_plen;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= 1'b0;
			rem_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				open_q <= open_d;
				rem_q  <= rem_d;
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

endmodule

>>> hdl/ufb_fifo.sv
// Short command queue between the front end and the frame sequencer.
// Depends on ufb_pkg.
`timescale 1ns / 1ps

module ufb_fifo #(
	parameter int DEPTH = ufb_pkg::FIFO_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ufb_pkg::ufb_cmd_t in_cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output ufb_pkg::ufb_cmd_t out_cmd
);
	import ufb_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ufb_cmd_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q != CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

>>> hdl/ufb_back.sv
// Back end: header byte sequencer, checksum fold and output register.
// Depends on ufb_pkg.
`timescale 1ns / 1ps

module ufb_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ufb_pkg::ufb_cfg_t             cfg,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  ufb_pkg::ufb_cmd_t             cmd,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// frame_byte
	output logic [ufb_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tlast,
	// error
	output logic                          m_tuser
);
	import ufb_pkg::*;

	ufb_back_state_t      state_q;
	ufb_back_state_t      state_d;
	logic [HDR_IDX_W-1:0] idx_q;
	logic [MAC_W-1:0]     dmac_q;
	logic [IP_W-1:0]      dip_q;
	logic [PORT_W-1:0]    dport_q;
	logic [PLEN_W-1:0]    plen_q;
	logic [SUM_W-1:0]     sum_q;

	logic                 valid_q;
	logic [BYTE_W-1:0]    byte_q;
	logic                 last_q;
	logic                 err_q;

	logic                 out_free;
	logic                 load;
	logic                 pop;
	logic [BYTE_W-1:0]    byte_d;
	logic                 last_d;
	logic                 err_d;

	assign out_free = !valid_q || m_tready;
	assign pop      = cmd_valid && cmd_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pop && cmd.kind == CMD_HDR) begin
					state_d = ST_HDR;
				end
			end
			ST_HDR: begin
				if (out_free && idx_q == HDR_LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = 1'b0;
		load      = 1'b0;
		byte_d    = '0;
		last_d    = 1'b0;
		err_d     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = out_free;
				load      = cmd_valid && out_free;
				unique case (cmd.kind)
					CMD_HDR:  byte_d = cmd.dst_mac[47:40];
					CMD_DATA: begin
						byte_d = cmd.data;
						last_d = cmd.last;
					end
					default:  err_d = 1'b1;
				endcase
			end
			ST_HDR: begin
				load   = out_free;
				byte_d = hdr_byte(idx_q, cfg, dmac_q, dip_q, dport_q, plen_q, ~sum_q[15:0]);
				last_d = (idx_q == HDR_LAST_IDX) && (plen_q == '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (out_free) begin
				valid_q <= load;
			end
			if (pop) begin
				idx_q <= HDR_IDX_W'(1);
			end else if (state_q == ST_HDR && out_free) begin
				idx_q <= idx_q + HDR_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= byte_d;
			last_q <= last_d;
			err_q  <= err_d;
		end
		if (pop) begin
			dmac_q  <= cmd.dst_mac;
			dip_q   <= cmd.dest_ip;
			dport_q <= cmd.dst_port;
			plen_q  <= cmd.plen;
			sum_q   <= SUM_W'(cmd.csum_part) + SUM_W'(cfg.source_ip[31:16]) +
				SUM_W'(cfg.source_ip[15:0]);
		end else if (state_q == ST_HDR) begin
			// end-around carry fold; settles long before the checksum bytes go out
			sum_q <= SUM_W'(sum_q[15:0]) + SUM_W'(sum_q[SUM_W-1:16]);
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = byte_q;
	assign m_tlast  = last_q;
	assign m_tuser  = err_q;

endmodule

>>> hdl/udp_ipv4_frame_builder.sv
// Accepted items pass the front stage register, the command queue and the output register. One
// result per cycle unless m_tready stalls it; the header sequencer yields 42 header bytes per start
// item, one error result per oversize start or stray payload item; payload bytes pass one per cycle.
// Input is taken every cycle until the command queue (FIFO_DEPTH entries) fills.
// Reset (arst_n low) clears the configuration registers, the open-packet state and the queue.
`timescale 1ns / 1ps

module udp_ipv4_frame_builder #(
	parameter int MAX_FRAME_BYTES = ufb_pkg::MAX_FRAME_BYTES_DEF,
	parameter int FIFO_DEPTH      = ufb_pkg::FIFO_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ufb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ufb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// dst_mac, dest_ip, dst_port, pay_len, payload_byte, zero fill
	input  logic [ufb_pkg::S_TDATA_W-1:0]  s_tdata,
	// operation
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// frame_byte
	output logic [ufb_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                           m_tlast,
	// error
	output logic                           m_tuser
);
	import ufb_pkg::*;

	ufb_cfg_t cfg_q;
	ufb_cmd_t front_cmd;
	ufb_cmd_t back_cmd;
	logic     front_valid;
	logic     front_ready;
	logic     back_valid;
	logic     back_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SOURCE_MAC:  cfg_q.source_mac  <= cfg_data[MAC_W-1:0];
				CFG_SOURCE_IP:   cfg_q.source_ip   <= cfg_data[IP_W-1:0];
				CFG_SOURCE_PORT: cfg_q.source_port <= cfg_data[PORT_W-1:0];
				default: ;
			endcase
		end
	end

	ufb_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd_valid(front_valid),
		.cmd_ready(front_ready),
		.cmd      (front_cmd)
	);

	ufb_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (front_valid),
		.in_ready (front_ready),
		.in_cmd   (front_cmd),
		.out_valid(back_valid),
		.out_ready(back_ready),
		.out_cmd  (back_cmd)
	);

	ufb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_valid(back_valid),
		.cmd_ready(back_ready),
		.cmd      (back_cmd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// an error result never closes a frame
	a_err_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tlast)
		else $error("error result flagged as last");

	// a held front stage must stall the input
	a_front_stall: assert property (@(posedge clk) disable iff (!arst_n)
		front_valid && !front_ready |-> !s_tready)
		else $error("input taken while front stage blocked");

	// the queue is only drained into a free output register
	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		back_valid && back_ready |-> !m_tvalid || m_tready)
		else $error("command popped while output register held");

endmodule
